// ===== design/assert_macros.svh =====
// Assertion macros shared by the keyboard scan code translator RTL.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KBD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kbd assertion failed");
`define KBD_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("kbd assertion failed");
`else
`define KBD_ASSERT(lbl, clk, rst, prop)
`define KBD_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif
`endif

// ===== design/kbd_pkg.sv =====
// Package for the keyboard scan code translator: key codes and layout tables.
// Depends on nothing.
`timescale 1ns / 1ps

package kbd_pkg;

   localparam int unsigned CODE_W = 7;
   localparam int unsigned CHAR_W = 7;

   localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
   localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
   localparam logic [CODE_W-1:0] KEY_CTRL   = 7'h1D;
   localparam logic [CODE_W-1:0] KEY_ALT    = 7'h38;
   localparam logic [CODE_W-1:0] KEY_CAPS   = 7'h3A;

   localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 7'h7A;
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 7'h5A;
   localparam logic [CHAR_W-1:0] CASE_BIT   = 7'h20;

   // US layout, unshifted
   function automatic logic [CHAR_W-1:0] plain_map(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'd1:  ch = 7'h1B;
         7'd2:  ch = 7'h31;
         7'd3:  ch = 7'h32;
         7'd4:  ch = 7'h33;
         7'd5:  ch = 7'h34;
         7'd6:  ch = 7'h35;
         7'd7:  ch = 7'h36;
         7'd8:  ch = 7'h37;
         7'd9:  ch = 7'h38;
         7'd10: ch = 7'h39;
         7'd11: ch = 7'h30;
         7'd12: ch = 7'h2D;
         7'd13: ch = 7'h3D;
         7'd14: ch = 7'h08;
         7'd15: ch = 7'h09;
         7'd16: ch = 7'h71;
         7'd17: ch = 7'h77;
         7'd18: ch = 7'h65;
         7'd19: ch = 7'h72;
         7'd20: ch = 7'h74;
         7'd21: ch = 7'h79;
         7'd22: ch = 7'h75;
         7'd23: ch = 7'h69;
         7'd24: ch = 7'h6F;
         7'd25: ch = 7'h70;
         7'd26: ch = 7'h5B;
         7'd27: ch = 7'h5D;
         7'd28: ch = 7'h0A;
         7'd30: ch = 7'h61;
         7'd31: ch = 7'h73;
         7'd32: ch = 7'h64;
         7'd33: ch = 7'h66;
         7'd34: ch = 7'h67;
         7'd35: ch = 7'h68;
         7'd36: ch = 7'h6A;
         7'd37: ch = 7'h6B;
         7'd38: ch = 7'h6C;
         7'd39: ch = 7'h3B;
         7'd40: ch = 7'h27;
         7'd41: ch = 7'h60;
         7'd43: ch = 7'h5C;
         7'd44: ch = 7'h7A;
         7'd45: ch = 7'h78;
         7'd46: ch = 7'h63;
         7'd47: ch = 7'h76;
         7'd48: ch = 7'h62;
         7'd49: ch = 7'h6E;
         7'd50: ch = 7'h6D;
         7'd51: ch = 7'h2C;
         7'd52: ch = 7'h2E;
         7'd53: ch = 7'h2F;
         7'd55: ch = 7'h2A;
         7'd57: ch = 7'h20;
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

   // US layout, shift held
   function automatic logic [CHAR_W-1:0] shifted_map(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'd1:  ch = 7'h1B;
         7'd2:  ch = 7'h21;
         7'd3:  ch = 7'h40;
         7'd4:  ch = 7'h23;
         7'd5:  ch = 7'h24;
         7'd6:  ch = 7'h25;
         7'd7:  ch = 7'h5E;
         7'd8:  ch = 7'h26;
         7'd9:  ch = 7'h2A;
         7'd10: ch = 7'h28;
         7'd11: ch = 7'h29;
         7'd12: ch = 7'h5F;
         7'd13: ch = 7'h2B;
         7'd14: ch = 7'h08;
         7'd15: ch = 7'h09;
         7'd16: ch = 7'h51;
         7'd17: ch = 7'h57;
         7'd18: ch = 7'h45;
         7'd19: ch = 7'h52;
         7'd20: ch = 7'h54;
         7'd21: ch = 7'h59;
         7'd22: ch = 7'h55;
         7'd23: ch = 7'h49;
         7'd24: ch = 7'h4F;
         7'd25: ch = 7'h50;
         7'd26: ch = 7'h7B;
         7'd27: ch = 7'h7D;
         7'd28: ch = 7'h0A;
         7'd30: ch = 7'h41;
         7'd31: ch = 7'h53;
         7'd32: ch = 7'h44;
         7'd33: ch = 7'h46;
         7'd34: ch = 7'h47;
         7'd35: ch = 7'h48;
         7'd36: ch = 7'h4A;
         7'd37: ch = 7'h4B;
         7'd38: ch = 7'h4C;
         7'd39: ch = 7'h3A;
         7'd40: ch = 7'h22;
         7'd41: ch = 7'h7E;
         7'd43: ch = 7'h7C;
         7'd44: ch = 7'h5A;
         7'd45: ch = 7'h58;
         7'd46: ch = 7'h43;
         7'd47: ch = 7'h56;
         7'd48: ch = 7'h42;
         7'd49: ch = 7'h4E;
         7'd50: ch = 7'h4D;
         7'd51: ch = 7'h3C;
         7'd52: ch = 7'h3E;
         7'd53: ch = 7'h3F;
         7'd55: ch = 7'h2A;
         7'd57: ch = 7'h20;
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

// ===== design/kbd_req_if.sv =====
// Request channel interface: one raw scan code byte per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface kbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_byte;

   modport source (output valid, output scan_byte, input ready);
   modport sink   (input valid, input scan_byte, output ready);
endinterface

// ===== design/kbd_rsp_if.sv =====
// Response channel interface: character and modifier flags per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface kbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       shift_held;
   logic       ctrl_held;
   logic       alt_held;
   logic       caps_on;

   modport source (output valid, output char_code, output shift_held, output ctrl_held,
                   output alt_held, output caps_on, input ready);
   modport sink   (input valid, input char_code, input shift_held, input ctrl_held,
                   input alt_held, input caps_on, output ready);
endinterface

// ===== design/keyboard_scancode_to_ascii_top.sv =====
// Scan code set 1 to ASCII translator, US layout, top level.
// Depends on kbd_pkg, kbd_req_if, kbd_rsp_if and assert_macros.svh.
//
//   channel    dir  payload                                    handshake
//   req_chan   in   scan_byte[7:0]                             valid/ready
//   rsp_chan   out  char_code[6:0], shift/ctrl/alt/caps flags  valid/ready
//
// One transaction per cycle sustained while rsp_chan is not stalled; a result
// reaches rsp_chan via the input register, then the result register with flags.
// Synchronous active-high reset clears the modifier flags and both valids.
// A stalled response holds its register; the input register takes a new byte
// only while empty as the response waits, then holds until the response moves.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyboard_scancode_to_ascii_top (
   input logic       clock,
   input logic       reset,
   kbd_req_if.sink   req_chan,
   kbd_rsp_if.source rsp_chan
);

   logic                           in_valid_ff;
   logic [7:0]                     in_byte_ff;
   logic                           out_valid_ff;
   logic [kbd_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                           shift_ff, shift_in;
   logic                           ctrl_ff, ctrl_in;
   logic                           alt_ff, alt_in;
   logic                           caps_ff, caps_in;

   logic                           out_load;
   logic                           in_adv;
   logic                           release_key;
   logic [kbd_pkg::CODE_W-1:0]     code;
   logic                           is_shift;
   logic [kbd_pkg::CHAR_W-1:0]     map_ch;

   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign in_adv         = in_valid_ff && out_load;
   assign req_chan.ready = !in_valid_ff || out_load;

   assign release_key = in_byte_ff[7];
   assign code        = in_byte_ff[6:0];
   assign is_shift    = (code == kbd_pkg::KEY_LSHIFT) || (code == kbd_pkg::KEY_RSHIFT);

   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      caps_in  = caps_ff;
      char_in  = kbd_pkg::CHAR_NONE;
      map_ch   = shift_ff ? kbd_pkg::shifted_map(code) : kbd_pkg::plain_map(code);
      if (release_key) begin
         if (is_shift) begin
            shift_in = 1'b0;
         end else if (code == kbd_pkg::KEY_CTRL) begin
            ctrl_in = 1'b0;
         end else if (code == kbd_pkg::KEY_ALT) begin
            alt_in = 1'b0;
         end
      end else if (is_shift) begin
         shift_in = 1'b1;
      end else if (code == kbd_pkg::KEY_CTRL) begin
         ctrl_in = 1'b1;
      end else if (code == kbd_pkg::KEY_ALT) begin
         alt_in = 1'b1;
      end else if (code == kbd_pkg::KEY_CAPS) begin
         caps_in = !caps_ff;
      end else begin
         char_in = map_ch;
         if (caps_ff && (((map_ch >= kbd_pkg::CHAR_LO_A) && (map_ch <= kbd_pkg::CHAR_LO_Z)) ||
                         ((map_ch >= kbd_pkg::CHAR_UP_A) && (map_ch <= kbd_pkg::CHAR_UP_Z)))) begin
            char_in = map_ch ^ kbd_pkg::CASE_BIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         alt_ff       <= 1'b0;
         caps_ff      <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (in_adv) begin
            shift_ff <= shift_in;
            ctrl_ff  <= ctrl_in;
            alt_ff   <= alt_in;
            caps_ff  <= caps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.scan_byte;
      end
      if (in_adv) begin
         char_ff <= char_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.char_code  = char_ff;
   assign rsp_chan.shift_held = shift_ff;
   assign rsp_chan.ctrl_held  = ctrl_ff;
   assign rsp_chan.alt_held   = alt_ff;
   assign rsp_chan.caps_on    = caps_ff;

   `KBD_ASSERT_NEXT(a_release_no_char, clock, reset, in_adv && in_byte_ff[7], char_ff == kbd_pkg::CHAR_NONE)
   `KBD_ASSERT_NEXT(a_caps_only_on_make, clock, reset, !(in_adv && (in_byte_ff == {1'b0, kbd_pkg::KEY_CAPS})), $stable(caps_ff))
   `KBD_ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !out_load, in_valid_ff && $stable(in_byte_ff))
   `KBD_ASSERT_NEXT(a_flags_move_with_result, clock, reset, !in_adv, $stable({shift_ff, ctrl_ff, alt_ff}))

endmodule
